>>> hdl/cbor_pkg.sv
`timescale 1ns / 1ps

package cbor_pkg;

    localparam int unsigned CFG_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned TIMER_W   = 8;
    localparam int unsigned RETRY_W   = 8;

    localparam logic [CFG_W-1:0] RECOVERY_DELAY_RST = 8'd100;
    localparam logic [CFG_W-1:0] FAIL_THRESHOLD_RST = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESHOLD = 2'd1;

    // event kind carried on tuser; the fourth code is unused
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_STEP   = 2'd1,
        OP_TXDONE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_REINIT = 2'd1,
        PH_WAIT   = 2'd2,
        PH_CHECK  = 2'd3
    } t_phase;

    localparam logic [1:0] NM_NONE    = 2'd0;
    localparam logic [1:0] NM_ENTERED = 2'd1;
    localparam logic [1:0] NM_CLEARED = 2'd2;

    localparam logic [1:0] DTC_NONE = 2'd0;
    localparam logic [1:0] DTC_PASS = 2'd1;
    localparam logic [1:0] DTC_FAIL = 2'd2;

    typedef struct packed {
        logic       tx_blocked;
        logic       bus_off_status;
        logic       recovery_start;
        logic       abort_and_release;
        logic [1:0] dtc_event;
        logic [1:0] nm_event;
    } t_result;

endpackage

>>> hdl/can_bus_off_recovery.sv
`timescale 1ns / 1ps

// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// in       | s_axis_tvalid/s_axis_tready| tuser[1:0] operation, tdata[0] bus_off_hold
// out      | m_axis_tvalid/m_axis_tready| tdata nm_event..tx_blocked (one result/item)
// config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One item per clock sustained while the output is not stalled; each item
// waits in the input register, then its state update and result are taken
// into the output register in the same edge.
// The state update is a single pass of compares and an 8-bit increment.
// Synchronous active-low reset clears state and both stages.
// A stalled output holds its result; the input stage still moves up when
// the output register is being emptied in the same cycle.

module can_bus_off_recovery (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [0] bus_off_hold, rest zero
    input  logic [1:0]                     s_axis_tuser,  // [1:0] operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] nm_event, [3:2] dtc_event, [4] abort_and_release,
    // [5] recovery_start, [6] bus_off_status, [7] tx_blocked
    output logic [7:0]                     m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [cbor_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbor_pkg::CFG_W-1:0]     i_cfg_data
);
    import cbor_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic       r_in_hold;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic       w_fire;

    // the input stage drains whenever the output register is free or emptying
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_hold <= s_axis_tdata[0];
        end
    end

    cbor_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_op       (r_in_op),
        .i_hold     (r_in_hold),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.tx_blocked, r_out.bus_off_status, r_out.recovery_start,
                            r_out.abort_and_release, r_out.dtc_event, r_out.nm_event};

endmodule

>>> hdl/cbor_core.sv
`timescale 1ns / 1ps

module cbor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cbor_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbor_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_fire,
    input  logic [1:0]                    i_op,
    input  logic                          i_hold,
    output cbor_pkg::t_result             o_res
);
    import cbor_pkg::*;

    logic [CFG_W-1:0]   r_recovery_delay;
    logic [CFG_W-1:0]   r_fail_threshold;
    t_phase             r_phase, n_phase;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [RETRY_W-1:0] r_retry, n_retry;
    logic               r_tx_done, n_tx_done;
    logic               w_check_ok;
    logic [RETRY_W-1:0] w_retry_inc;
    t_result            w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recovery_delay <= RECOVERY_DELAY_RST;
            r_fail_threshold <= FAIL_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RECOVERY_DELAY: r_recovery_delay <= i_cfg_data;
                CFG_FAIL_THRESHOLD: r_fail_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_check_ok  = !i_hold && r_tx_done;
    assign w_retry_inc = (r_retry == {RETRY_W{1'b1}}) ? r_retry : r_retry + 1'b1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_op == OP_STEP) begin
            unique case (r_phase)
                PH_IDLE:   if (i_hold) n_phase = PH_REINIT;
                PH_REINIT: n_phase = PH_WAIT;
                PH_WAIT:   if (r_timer == '0) n_phase = PH_CHECK;
                PH_CHECK:  n_phase = w_check_ok ? PH_IDLE : PH_REINIT;
                default:   n_phase = r_phase;
            endcase
        end
    end

    // datapath updates and result strobes
    always_comb begin
        n_timer   = r_timer;
        n_retry   = r_retry;
        n_tx_done = r_tx_done;
        w_res     = '0;
        case (i_op)
            OP_TICK: begin
                if (r_timer != '0) n_timer = r_timer - 1'b1;
            end
            OP_TXDONE: begin
                n_tx_done = 1'b1;
            end
            OP_STEP: begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_hold) begin
                            w_res.nm_event = NM_ENTERED;
                            n_retry        = '0;
                            n_tx_done      = 1'b0;
                        end else begin
                            w_res.dtc_event = DTC_PASS;
                        end
                    end
                    PH_REINIT: begin
                        w_res.abort_and_release = 1'b1;
                        n_timer                 = r_recovery_delay;
                    end
                    PH_WAIT: begin
                        if (r_timer == '0) w_res.recovery_start = 1'b1;
                    end
                    PH_CHECK: begin
                        if (w_check_ok) begin
                            w_res.nm_event = NM_CLEARED;
                        end else begin
                            n_retry   = w_retry_inc;
                            n_tx_done = 1'b0;
                            if (w_retry_inc >= r_fail_threshold) w_res.dtc_event = DTC_FAIL;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        w_res.bus_off_status = !(n_phase == PH_IDLE && !i_hold);
        w_res.tx_blocked     = (n_timer != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_retry   <= '0;
            r_tx_done <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_retry   <= n_retry;
            r_tx_done <= n_tx_done;
        end
    end

    assign o_res = w_res;

    a_tick_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_op == OP_TICK && r_timer != '0 |=> r_timer == $past(r_timer) - 1'b1)
        else $error("delay timer did not count down on tick");

    a_retry_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase != PH_IDLE |=> r_retry >= $past(r_retry))
        else $error("retry count decreased outside idle");

    a_start_after_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.recovery_start |-> r_phase == PH_WAIT && r_timer == '0)
        else $error("recovery start before delay expired");

    a_release_loads_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_res.abort_and_release |=>
            r_phase == PH_WAIT && r_timer == $past(r_recovery_delay))
        else $error("release did not load the delay timer");

    a_fail_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.dtc_event == DTC_FAIL |-> r_phase == PH_CHECK && n_phase == PH_REINIT)
        else $error("fail report outside a failed recovery check");

endmodule
